/* sv/sfg_pkg.sv */
// ----------------------------------------------------------------------------
// sfg_pkg
// Types, control-word layout and gap table shared by the shell sort core
// ----------------------------------------------------------------------------
package sfg_pkg;

  localparam int GAP_COUNT = 16;
  localparam int GAP_W     = 21;
  localparam int GI_W      = $clog2(GAP_COUNT);
  localparam int G_W       = GI_W + 1;
  localparam int STEP_W    = 4;

  localparam logic [GAP_W-1:0] GAP_TABLE [GAP_COUNT] = '{
    21'd1391376, 21'd463792, 21'd198768, 21'd86961,
    21'd33936,   21'd13776,  21'd4592,   21'd1968,
    21'd861,     21'd336,    21'd112,    21'd48,
    21'd21,      21'd7,      21'd3,      21'd1
  };

  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t ST_LOAD  = 4'd0;
  localparam step_t ST_GTEST = 4'd1;
  localparam step_t ST_GSKIP = 4'd2;
  localparam step_t ST_ITEST = 4'd3;
  localparam step_t ST_HOLD  = 4'd4;
  localparam step_t ST_JTEST = 4'd5;
  localparam step_t ST_CMP   = 4'd6;
  localparam step_t ST_SHIFT = 4'd7;
  localparam step_t ST_WR    = 4'd8;
  localparam step_t ST_ORD   = 4'd9;
  localparam step_t ST_OWAIT = 4'd10;
  localparam step_t ST_BACK  = 4'd11;
  localparam step_t ST_DONE  = 4'd12;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LAST_ACC,
    C_G_END,
    C_SKIP,
    C_I_GE_N,
    C_J_LT_GAP,
    C_NOT_GT,
    C_K_EQ_N,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_I,
    RD_JG,
    RD_K
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_HOLD
  } wr_sel_t;

  typedef struct packed {
    logic    in_rdy;
    logic    g_clr;
    logic    g_inc;
    logic    gap_ld;
    logic    i_ld;
    logic    i_inc;
    logic    j_ld;
    logic    j_sub;
    logic    hold_ld;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    out_ld;
    logic    k_clr;
    logic    batch_clr;
    cond_t   cond;
    step_t   target;
  } ctl_t;

  typedef struct packed {
    logic last_acc;
    logic g_end;
    logic gap_skip;
    logic i_ge_n;
    logic j_lt_gap;
    logic not_gt;
    logic k_eq_n;
    logic out_busy;
  } stat_t;

  localparam ctl_t CTL_NOP = '{
    in_rdy: 1'b0, g_clr: 1'b0, g_inc: 1'b0, gap_ld: 1'b0, i_ld: 1'b0,
    i_inc: 1'b0, j_ld: 1'b0, j_sub: 1'b0, hold_ld: 1'b0, rd_sel: RD_NONE,
    wr_sel: WR_NONE, out_ld: 1'b0, k_clr: 1'b0, batch_clr: 1'b0,
    cond: C_NEVER, target: ST_LOAD
  };

endpackage

/* sv/sfg_ram.sv */
// ----------------------------------------------------------------------------
// sfg_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module sfg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sfg_seq.sv */
// ----------------------------------------------------------------------------
// sfg_seq
// Step counter and control-word ROM for the shell sort program
// ----------------------------------------------------------------------------
module sfg_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  sfg_pkg::stat_t stat,
  output sfg_pkg::ctl_t  ctl
);
  import sfg_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  function automatic ctl_t rom_word(input step_t s);
    ctl_t w;
    w = CTL_NOP;
    case (s)
      ST_LOAD: begin
        w.in_rdy = 1'b1; w.g_clr = 1'b1; w.k_clr = 1'b1;
        w.cond = C_NOT_LAST_ACC; w.target = ST_LOAD;
      end
      ST_GTEST: begin
        w.gap_ld = 1'b1; w.g_inc = 1'b1;
        w.cond = C_G_END; w.target = ST_ORD;
      end
      ST_GSKIP: begin
        w.i_ld = 1'b1;
        w.cond = C_SKIP; w.target = ST_GTEST;
      end
      ST_ITEST: begin
        w.rd_sel = RD_I; w.j_ld = 1'b1;
        w.cond = C_I_GE_N; w.target = ST_GTEST;
      end
      ST_HOLD: begin
        w.hold_ld = 1'b1;
      end
      ST_JTEST: begin
        w.rd_sel = RD_JG;
        w.cond = C_J_LT_GAP; w.target = ST_WR;
      end
      ST_CMP: begin
        w.cond = C_NOT_GT; w.target = ST_WR;
      end
      ST_SHIFT: begin
        w.wr_sel = WR_SHIFT; w.j_sub = 1'b1;
        w.cond = C_ALWAYS; w.target = ST_JTEST;
      end
      ST_WR: begin
        w.wr_sel = WR_HOLD; w.i_inc = 1'b1;
        w.cond = C_ALWAYS; w.target = ST_ITEST;
      end
      ST_ORD: begin
        w.rd_sel = RD_K;
        w.cond = C_K_EQ_N; w.target = ST_DONE;
      end
      ST_OWAIT: begin
        w.out_ld = 1'b1;
        w.cond = C_OUT_BUSY; w.target = ST_OWAIT;
      end
      ST_BACK: begin
        w.cond = C_ALWAYS; w.target = ST_ORD;
      end
      ST_DONE: begin
        w.batch_clr = 1'b1;
        w.cond = C_ALWAYS; w.target = ST_LOAD;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_LOAD;
      end
    endcase
    return w;
  endfunction

  // control word lookup
  always_comb begin
    ctl = rom_word(step_r);
  end

  // next step
  always_comb begin
    case (ctl.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NOT_LAST_ACC: take = !stat.last_acc;
      C_G_END:        take = stat.g_end;
      C_SKIP:         take = stat.gap_skip;
      C_I_GE_N:       take = stat.i_ge_n;
      C_J_LT_GAP:     take = stat.j_lt_gap;
      C_NOT_GT:       take = stat.not_gt;
      C_K_EQ_N:       take = stat.k_eq_n;
      C_OUT_BUSY:     take = stat.out_busy;
      default:        take = 1'b1;
    endcase
    step_nxt = take ? ctl.target : step_t'(step_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* sv/shell_sort_fixed_gaps_core.sv */
// ----------------------------------------------------------------------------
// shell_sort_fixed_gaps_core
// Batch loader and shell sorter with a fixed gap sequence, sorted words out
// ----------------------------------------------------------------------------
// Words are loaded one per cycle while the core is in its load step; a word
// with tlast closes the batch, which is then sorted in place in a store with
// one write and one registered read port, by gapped insertion passes driven by
// a small microprogram. A gap not smaller than the batch is skipped; for any
// other gap each element is held and larger elements a gap below it are shifted
// up until its place is found, then it is written there. The run is then read
// out one result at a time through the registered read port, each result
// waiting while the output register is still held. Words past MAX_ITEMS are
// dropped and the whole run is flagged in out_tuser. The core accepts no input
// between the closing word and the end of its run.
// ----------------------------------------------------------------------------
module shell_sort_fixed_gaps_core #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // item_value
  input  logic        in_tlast,   // batch_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sorted_value
  output logic        out_tlast,  // run_last
  output logic [0:0]  out_tuser   // overflowed
);
  import sfg_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

  ctl_t  ctl;
  stat_t stat;

  logic [CW-1:0]         fill_r, i_r, j_r, k_r, gap_r;
  logic [G_W-1:0]        g_r;
  logic                  ovf_r, gap_skip_r;
  logic [VALUE_BITS-1:0] hold_r, rdata;
  logic [15:0]           out_data_r;
  logic                  out_valid_r, out_last_r, out_ovf_r;

  logic                  in_acc, full, out_busy, out_ld_en;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [CW-1:0]         jg;

  assign in_tready = ctl.in_rdy;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (fill_r == FULL);
  assign out_busy  = out_valid_r && !out_tready;
  assign out_ld_en = ctl.out_ld && !out_busy;
  assign jg        = j_r - gap_r;

  always_comb begin
    stat.last_acc = in_acc && in_tlast;
    stat.g_end    = (g_r == G_W'(GAP_COUNT));
    stat.gap_skip = gap_skip_r;
    stat.i_ge_n   = (i_r >= fill_r);
    stat.j_lt_gap = (j_r < gap_r);
    stat.not_gt   = !(rdata > hold_r);
    stat.k_eq_n   = (k_r == fill_r);
    stat.out_busy = out_busy;
  end

  sfg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // store port selection
  always_comb begin
    we    = 1'b0;
    waddr = fill_r[AW-1:0];
    wdata = VALUE_BITS'(in_tdata);
    case (ctl.wr_sel)
      WR_SHIFT: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = rdata;
      end
      WR_HOLD: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = hold_r;
      end
      default: begin
        we = in_acc && !full;
      end
    endcase
    re    = 1'b1;
    raddr = i_r[AW-1:0];
    case (ctl.rd_sel)
      RD_I:    raddr = i_r[AW-1:0];
      RD_JG:   raddr = jg[AW-1:0];
      RD_K:    raddr = k_r[AW-1:0];
      default: re = 1'b0;
    endcase
  end

  sfg_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      g_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.batch_clr) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end else if (in_acc) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (ctl.g_clr) begin
        g_r <= '0;
      end else if (ctl.g_inc) begin
        g_r <= g_r + 1'b1;
      end
      if (ctl.k_clr) begin
        k_r <= '0;
      end else if (out_ld_en) begin
        k_r <= k_r + 1'b1;
      end
      if (out_ld_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sort datapath
  always_ff @(posedge clk) begin
    if (ctl.gap_ld) begin
      gap_skip_r <= (GAP_TABLE[g_r[GI_W-1:0]] >= GAP_W'(fill_r));
      gap_r      <= GAP_TABLE[g_r[GI_W-1:0]][CW-1:0];
    end
    if (ctl.i_ld) begin
      i_r <= gap_r;
    end else if (ctl.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (ctl.j_ld) begin
      j_r <= i_r;
    end else if (ctl.j_sub) begin
      j_r <= jg;
    end
    if (ctl.hold_ld) begin
      hold_r <= rdata;
    end
    if (out_ld_en) begin
      out_data_r <= 16'(rdata);
      out_last_r <= (CW'(k_r + 1'b1) == fill_r);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond store depth");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> ovf_r)
    else $error("dropped word did not set overflow");

  a_sort_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_sel != WR_NONE) |-> (j_r < fill_r))
    else $error("sort write outside the batch");

  a_out_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld_en |-> (k_r < fill_r))
    else $error("result read outside the batch");

  a_no_load_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (ctl.wr_sel == WR_NONE && !ctl.out_ld))
    else $error("input taken while sorting or emitting");

endmodule

/* tb/sv/sort_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// sort_scoreboard_pkg
// Batch predictor and result checker for the shell sort core testbench
// ----------------------------------------------------------------------------
// Keeps its own copy of the batch store, fill count and overflow flag. A
// closing word sorts the stored batch and queues one expected word per
// stored value. Output words are checked in order against that queue.
// ----------------------------------------------------------------------------
package sort_scoreboard_pkg;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  class sort_scoreboard;
    int unsigned  depth;
    logic [15:0]  batch_vals[$];
    bit           dropped;
    sorted_word_t pending_words[$];
    int unsigned  fails;

    function new(int unsigned store_depth);
      depth = store_depth;
      dropped = 1'b0;
      fails = 0;
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    task report(string msg);
      // keep the log short if everything goes wrong
      if (fails < 40) $display("mismatch: %s", msg);
      fails++;
    endtask

    // ascending insertion sort of the batch held so far
    function void order_batch();
      int unsigned i;
      int unsigned j;
      logic [15:0] hold;
      for (i = 1; i < batch_vals.size(); i++) begin
        hold = batch_vals[i];
        j = i;
        while (j > 0 && batch_vals[j-1] > hold) begin
          batch_vals[j] = batch_vals[j-1];
          j--;
        end
        batch_vals[j] = hold;
      end
    endfunction

    function void note_word(logic [15:0] value, logic last);
      sorted_word_t w;
      int unsigned k;
      // a full store drops the word, the closing one included
      if (batch_vals.size() < depth) batch_vals = {batch_vals, value};
      else dropped = 1'b1;
      if (last) begin
        order_batch();
        for (k = 0; k < batch_vals.size(); k++) begin
          w.value = batch_vals[k];
          w.last  = (k + 1 == batch_vals.size());
          w.ovf   = dropped;
          pending_words = {pending_words, w};
        end
        batch_vals.delete();
        dropped = 1'b0;
      end
    endfunction

    task check_word(logic [15:0] value, logic last, logic ovf);
      sorted_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %h last %b ovf %b", value, last, ovf));
      end else begin
        w = pending_words.pop_front();
        if (value !== w.value)
          report($sformatf("value %h, expected %h", value, w.value));
        if (last !== w.last)
          report($sformatf("last %b, expected %b (value %h)", last, w.last, w.value));
        if (ovf !== w.ovf)
          report($sformatf("overflow %b, expected %b (value %h)", ovf, w.ovf, w.value));
      end
    endtask
  endclass

endpackage

/* tb/sv/shell_sort_fixed_gaps_core_tb.sv */
// ----------------------------------------------------------------------------
// shell_sort_fixed_gaps_core_tb
// Self-checking bench for the batch shell sort core
// ----------------------------------------------------------------------------
// Sends directed batches (single words, extremes, duplicates, reversed order,
// a batch filling the store exactly and one overrunning it with its closing
// word dropped), then random batches under four idle/stall mixes, with one
// long output hold-off. Every output word is checked against the predictor.
// ----------------------------------------------------------------------------
module shell_sort_fixed_gaps_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sort_scoreboard_pkg::*;

  localparam int          MAX_ITEMS    = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_WORDS  = 20;
  localparam int          IDLE_PCT [4] = '{0, 56, 0, 35};
  localparam int          STALL_PCT[4] = '{0, 0, 56, 35};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  sort_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    sent_words = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    hold_cnt = 0;
  logic           hold_req = 1'b0;
  logic           hold_ack = 1'b0;

  shell_sort_fixed_gaps_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: check accepted words, drive tready, run the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast, out_tuser[0]);
      if (hold_req != hold_ack) begin
        hold_ack   <= hold_req;
        hold_cnt   <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [15:0] rand_value();
    // narrow values now and then so batches carry duplicates
    if ($urandom_range(3) == 0) return 16'($urandom_range(3));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic send_word(input logic [15:0] value, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_word(value, last);
    sent_words++;
  endtask

  task automatic send_batch(input logic [15:0] vals[$]);
    int unsigned k;
    for (k = 0; k < vals.size(); k++) send_word(vals[k], k + 1 == vals.size());
  endtask

  task automatic send_random_batch(input int unsigned len);
    logic [15:0] vals[$];
    int unsigned k;
    for (k = 0; k < len; k++) vals = {vals, rand_value()};
    send_batch(vals);
  endtask

  initial begin
    logic [15:0] vals[$];
    int unsigned ph;
    int unsigned goal;
    int unsigned len;

    sb = new(MAX_ITEMS);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    vals = {16'h0000};
    send_batch(vals);
    vals = {16'hFFFF};
    send_batch(vals);
    vals = {16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF};
    send_batch(vals);
    vals = {16'h1234, 16'h1234, 16'h1234};
    send_batch(vals);
    vals = {16'h0009, 16'h0007, 16'h0005, 16'h0003, 16'h0001, 16'h0000};
    send_batch(vals);
    vals = {16'hAAAA, 16'h5555};
    send_batch(vals);

    // store filled exactly, then overrun so the closing word is dropped
    send_random_batch(MAX_ITEMS);
    send_random_batch(MAX_ITEMS + 2);

    // let the core drain completely before the random part
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = IDLE_PCT[ph];
      stall_pct <= STALL_PCT[ph];
      // long output hold-off while words keep coming, fills the core up
      if (ph == 0) hold_req <= ~hold_req;
      goal = sent_words + PHASE_WORDS;
      while (sent_words < goal) begin
        if ($urandom_range(11) == 0) len = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS - 4);
        else len = $urandom_range(8, 1);
        // keep each phase to its word budget
        if (len > goal - sent_words) len = goal - sent_words;
        send_random_batch(len);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected words left over at the end");
    if (sb.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
